// File: sv/hsi_pkg.sv
package hsi_pkg;

    // raw gas converter width
    localparam int GasSampleBits = 12;

    localparam int CfgIdxWidth  = 3;
    localparam int CfgDataWidth = 16;

    // configuration register indexes
    localparam logic [CfgIdxWidth-1:0] CFG_STALE_LIMIT   = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_GAS_ALERT     = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_GAS_RECOVERY  = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_CONFIRM_COUNT = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_RECOVER_COUNT = 3'd4;
    localparam logic [CfgIdxWidth-1:0] CFG_FAN_PERCENT   = 3'd5;

    // safety state codes
    localparam logic [1:0] ST_NORMAL  = 2'd0;
    localparam logic [1:0] ST_WARMING = 2'd1;
    localparam logic [1:0] ST_FAULT   = 2'd2;
    localparam logic [1:0] ST_RISK    = 2'd3;

    // primary cause codes
    localparam logic [2:0] CAUSE_NONE  = 3'd0;
    localparam logic [2:0] CAUSE_FLAME = 3'd1;
    localparam logic [2:0] CAUSE_GAS   = 3'd2;
    localparam logic [2:0] CAUSE_WATER = 3'd3;
    localparam logic [2:0] CAUSE_FAULT = 3'd4;

    // servo codes
    localparam logic [1:0] SERVO_HOLD   = 2'd0;
    localparam logic [1:0] SERVO_VENT   = 2'd1;
    localparam logic [1:0] SERVO_CLOSED = 2'd2;

    // buzzer codes
    localparam logic [1:0] BUZZ_OFF   = 2'd0;
    localparam logic [1:0] BUZZ_INTER = 2'd1;
    localparam logic [1:0] BUZZ_ALARM = 2'd2;

    // light codes
    localparam logic [2:0] LIGHT_NONE    = 3'd0;
    localparam logic [2:0] LIGHT_GRAY    = 3'd1;
    localparam logic [2:0] LIGHT_BLUERED = 3'd2;
    localparam logic [2:0] LIGHT_RED     = 3'd3;
    localparam logic [2:0] LIGHT_YELLOW  = 3'd4;

    // override mask bits
    localparam logic [4:0] MASK_ALL     = 5'h1F;
    localparam logic [4:0] MASK_WARMING = 5'h1D;
    localparam logic [4:0] MASK_WATER   = 5'h1C;

    typedef struct packed {
        logic [31:0]              now_ms;
        logic                     gas_valid;
        logic [31:0]              gas_stamp_ms;
        logic [GasSampleBits-1:0] gas_raw;
        logic                     gas_warmed_up;
        logic                     water_valid;
        logic [31:0]              water_stamp_ms;
        logic                     water_detected;
        logic                     flame_valid;
        logic [31:0]              flame_stamp_ms;
        logic                     flame_detected;
    } t_in_req;

    typedef struct packed {
        logic [1:0] safety_state;
        logic [3:0] cause_flags;
        logic [2:0] primary_cause;
        logic       override_active;
        logic       buzzer_requested;
        logic [4:0] override_mask;
        logic [6:0] fan_percent;
        logic [1:0] servo_position;
        logic       relay_on;
        logic [1:0] buzzer_mode;
        logic [2:0] light_state;
    } t_out_req;

    typedef struct packed {
        logic [15:0]              stale_limit_ms;
        logic [GasSampleBits-1:0] gas_alert_level;
        logic [GasSampleBits-1:0] gas_recovery_level;
        logic [7:0]               confirm_count;
        logic [7:0]               recovery_count;
        logic [6:0]               gas_fan_duty;
    } t_cfg;

endpackage

// File: sv/hsi_cfg.sv
module hsi_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [hsi_pkg::CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [hsi_pkg::CfgDataWidth-1:0] i_cfg_data,
    output hsi_pkg::t_cfg                    o_cfg
);
    import hsi_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stale_limit_ms     <= 16'd3000;
            r_cfg.gas_alert_level    <= GasSampleBits'(2000);
            r_cfg.gas_recovery_level <= GasSampleBits'(1500);
            r_cfg.confirm_count      <= 8'd3;
            r_cfg.recovery_count     <= 8'd3;
            r_cfg.gas_fan_duty       <= 7'd100;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_STALE_LIMIT:   r_cfg.stale_limit_ms     <= i_cfg_data;
                CFG_GAS_ALERT:     r_cfg.gas_alert_level    <= i_cfg_data[GasSampleBits-1:0];
                CFG_GAS_RECOVERY:  r_cfg.gas_recovery_level <= i_cfg_data[GasSampleBits-1:0];
                CFG_CONFIRM_COUNT: r_cfg.confirm_count      <= i_cfg_data[7:0];
                CFG_RECOVER_COUNT: r_cfg.recovery_count     <= i_cfg_data[7:0];
                CFG_FAN_PERCENT:   r_cfg.gas_fan_duty       <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/hsi_core.sv
module hsi_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  hsi_pkg::t_in_req  i_req,
    input  hsi_pkg::t_cfg     i_cfg,
    output hsi_pkg::t_out_req o_rsp
);
    import hsi_pkg::*;

    typedef struct packed {
        logic       alarm;
        logic       held;
        logic [7:0] run;
    } t_held;

    function automatic logic fresh_chk(logic valid, logic [31:0] stamp,
                                       logic [31:0] now, logic [15:0] limit);
        logic [31:0] age;
        age = now - stamp;
        return valid && (stamp != 32'd0) && (age <= {16'd0, limit});
    endfunction

    function automatic t_held held_next(logic fresh, logic det, t_held cur,
                                        logic [7:0] rc);
        t_held      nx;
        logic [7:0] run;
        nx  = cur;
        run = cur.run;
        if (!fresh) begin
            if (cur.alarm) nx.held = 1'b1;
            nx.run = 8'd0;
        end else if (det) begin
            nx.alarm = 1'b1;
            nx.held  = 1'b0;
            nx.run   = 8'd0;
        end else if (cur.alarm && cur.held) begin
            if (run < rc) run = run + 8'd1;
            if (run >= rc) begin
                nx.alarm = 1'b0;
                nx.held  = 1'b0;
                nx.run   = 8'd0;
            end else begin
                nx.run = run;
            end
        end else begin
            nx.alarm = 1'b0;
            nx.run   = 8'd0;
        end
        return nx;
    endfunction

    logic       r_gas_alarm, n_gas_alarm;
    logic [7:0] r_gas_alert_run, n_gas_alert_run;
    logic [7:0] r_gas_clear_run, n_gas_clear_run;
    t_held      r_water, n_water;
    t_held      r_flame, n_flame;

    logic gas_fresh, water_fresh, flame_fresh, fault, risk;
    logic [7:0] inc_alert, inc_clear;

    assign gas_fresh   = fresh_chk(i_req.gas_valid, i_req.gas_stamp_ms, i_req.now_ms,
                                   i_cfg.stale_limit_ms);
    assign water_fresh = fresh_chk(i_req.water_valid, i_req.water_stamp_ms, i_req.now_ms,
                                   i_cfg.stale_limit_ms);
    assign flame_fresh = fresh_chk(i_req.flame_valid, i_req.flame_stamp_ms, i_req.now_ms,
                                   i_cfg.stale_limit_ms);
    assign fault = !gas_fresh || !water_fresh || !flame_fresh;

    // saturating run counters stop at the configured count
    assign inc_alert = (r_gas_alert_run < i_cfg.confirm_count) ?
                       r_gas_alert_run + 8'd1 : r_gas_alert_run;
    assign inc_clear = (r_gas_clear_run < i_cfg.recovery_count) ?
                       r_gas_clear_run + 8'd1 : r_gas_clear_run;

    always_comb begin
        n_gas_alarm     = r_gas_alarm;
        n_gas_alert_run = 8'd0;
        n_gas_clear_run = 8'd0;
        if (!i_req.gas_warmed_up) begin
            n_gas_alarm = 1'b0;
        end else if (gas_fresh) begin
            if (r_gas_alarm) begin
                if (i_req.gas_raw <= i_cfg.gas_recovery_level) begin
                    if (inc_clear >= i_cfg.recovery_count) n_gas_alarm = 1'b0;
                    else n_gas_clear_run = inc_clear;
                end
            end else begin
                if (i_req.gas_raw >= i_cfg.gas_alert_level) begin
                    if (inc_alert >= i_cfg.confirm_count) n_gas_alarm = 1'b1;
                    else n_gas_alert_run = inc_alert;
                end
            end
        end
        n_water = held_next(water_fresh, i_req.water_detected, r_water, i_cfg.recovery_count);
        n_flame = held_next(flame_fresh, i_req.flame_detected, r_flame, i_cfg.recovery_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gas_alarm     <= 1'b0;
            r_gas_alert_run <= 8'd0;
            r_gas_clear_run <= 8'd0;
            r_water         <= '0;
            r_flame         <= '0;
        end else if (i_step) begin
            r_gas_alarm     <= n_gas_alarm;
            r_gas_alert_run <= n_gas_alert_run;
            r_gas_clear_run <= n_gas_clear_run;
            r_water         <= n_water;
            r_flame         <= n_flame;
        end
    end

    assign risk = n_flame.alarm || n_gas_alarm || n_water.alarm;

    always_comb begin
        o_rsp = '0;
        o_rsp.cause_flags = {fault, n_water.alarm, n_gas_alarm, n_flame.alarm};
        if (n_flame.alarm)      o_rsp.primary_cause = CAUSE_FLAME;
        else if (n_gas_alarm)   o_rsp.primary_cause = CAUSE_GAS;
        else if (n_water.alarm) o_rsp.primary_cause = CAUSE_WATER;
        else if (fault)         o_rsp.primary_cause = CAUSE_FAULT;
        else                    o_rsp.primary_cause = CAUSE_NONE;

        if (risk)                      o_rsp.safety_state = ST_RISK;
        else if (fault)                o_rsp.safety_state = ST_FAULT;
        else if (!i_req.gas_warmed_up) o_rsp.safety_state = ST_WARMING;
        else                           o_rsp.safety_state = ST_NORMAL;

        o_rsp.buzzer_requested = risk;
        o_rsp.relay_on         = 1'b0;

        if (o_rsp.safety_state == ST_WARMING) begin
            o_rsp.override_active = 1'b1;
            o_rsp.override_mask   = MASK_WARMING;
            o_rsp.light_state     = LIGHT_YELLOW;
        end else begin
            // later overrides win: fault, water, gas, flame
            if (fault) begin
                o_rsp.override_mask = MASK_ALL;
                o_rsp.light_state   = LIGHT_GRAY;
            end
            if (n_water.alarm) begin
                o_rsp.override_mask = o_rsp.override_mask | MASK_WATER;
                o_rsp.buzzer_mode   = BUZZ_INTER;
                o_rsp.light_state   = LIGHT_BLUERED;
            end
            if (n_gas_alarm) begin
                o_rsp.override_mask  = MASK_ALL;
                o_rsp.fan_percent    = i_cfg.gas_fan_duty;
                o_rsp.servo_position = SERVO_VENT;
                o_rsp.buzzer_mode    = BUZZ_ALARM;
                o_rsp.light_state    = LIGHT_RED;
            end
            if (n_flame.alarm) begin
                o_rsp.override_mask  = MASK_ALL;
                o_rsp.fan_percent    = 7'd0;
                o_rsp.servo_position = SERVO_CLOSED;
                o_rsp.buzzer_mode    = BUZZ_ALARM;
                o_rsp.light_state    = LIGHT_RED;
            end
            o_rsp.override_active = fault || risk;
        end
    end

endmodule

// File: sv/hazard_sensor_safety_interlock_unit.sv
// Hazard interlock: each request is one evaluation tick with the current time and the gas,
// water and flame readings; each request yields exactly one response with the safety state,
// cause flags, primary cause and actuator overrides. A request can be taken every clock cycle
// while responses are being taken; a response is valid after its request passes the input
// register, then the response register; the alarm state advances as the request moves from
// the input register into the response register. The single evaluation pass between those
// two registers sets the rate. A stalled response holds the request behind it.
// Configuration registers may only be written while no request is in flight.
module hazard_sensor_safety_interlock_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  hsi_pkg::t_in_req                 i_req,
    output logic                             o_valid,
    input  logic                             i_ready,
    output hsi_pkg::t_out_req                o_rsp,
    input  logic                             i_cfg_wr_en,
    input  logic [hsi_pkg::CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [hsi_pkg::CfgDataWidth-1:0] i_cfg_data
);
    import hsi_pkg::*;

    t_in_req  r_in;
    logic     r_in_valid;
    t_out_req r_out;
    logic     r_out_valid;
    t_out_req core_rsp;
    t_cfg     cfg;
    logic     advance;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    hsi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    hsi_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_req   (r_in),
        .i_cfg   (cfg),
        .o_rsp   (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule
